// File: hw/rtl/pdto_pkg.sv
// types and constants shared by the pixel difference overlay pipeline
// no dependencies; every other file of the block refers to it by scoped names
package pdto_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  // input transaction: one pixel pair
  typedef struct packed {
    argb_t ref_pixel;
    argb_t cmp_pixel;
    logic  ref_outside;
  } pair_t;

  // output transaction: one overlay pixel
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } ovl_t;

  typedef enum logic [1:0] {
    KIND_OUTSIDE,
    KIND_GRAY,
    KIND_RED,
    KIND_BLUE
  } kind_t;

  // state carried through the classify and divide stages
  typedef struct packed {
    kind_t       kind;
    argb_t       cmp;
    logic [7:0]  diff;
    logic [7:0]  thr;
    logic [15:0] rem;
    logic [7:0]  quo;
    logic [9:0]  red_t;
    logic [8:0]  red_q;
  } work_t;

  // blend numerators, scaled by 1000
  typedef struct packed {
    logic [17:0] num_red;
    logic [17:0] num_green;
    logic [17:0] num_blue;
    logic [7:0]  alpha;
  } blend_t;

  localparam logic [9:0]  ALPHA_FULL    = 10'd1000;
  localparam logic [9:0]  ALPHA_OUTSIDE = 10'd600;
  localparam logic [9:0]  ALPHA_RED_MAX = 10'd600;
  localparam logic [9:0]  RED_BASE      = 10'd250;
  localparam logic [9:0]  BLUE_BASE     = 10'd100;
  localparam logic [9:0]  T_MAX         = 10'd1000;
  localparam logic [7:0]  BLUE_SCALE    = 8'd200;

  localparam logic [7:0]  RED_TGT_R  = 8'd255;
  localparam logic [7:0]  RED_TGT_G  = 8'd50;
  localparam logic [7:0]  RED_TGT_B  = 8'd50;
  localparam logic [7:0]  BLUE_TGT_R = 8'd60;
  localparam logic [7:0]  BLUE_TGT_G = 8'd100;
  localparam logic [7:0]  BLUE_TGT_B = 8'd255;

  localparam logic [9:0]  GRAY_W_R = 10'd299;
  localparam logic [9:0]  GRAY_W_G = 10'd587;
  localparam logic [9:0]  GRAY_W_B = 10'd114;

  // d*1500/255 == (d*100)*61681 >> 20, exact over the 8-bit range
  localparam logic [22:0] RED_T_MUL   = 23'd6168100;
  localparam int          RED_T_SHIFT = 20;
  // x/5 == x*52429 >> 18 for x below 2^18
  localparam logic [15:0] DIV5_MUL    = 16'd52429;
  localparam int          DIV5_SHIFT  = 18;
  // x/1000 == x*134218 >> 27 for x up to 255000
  localparam logic [17:0] DIV1000_MUL   = 18'd134218;
  localparam int          DIV1000_SHIFT = 27;

endpackage

// File: hw/rtl/pixel_diff_tolerance_overlay_unit.sv
// top level of the pixel difference overlay: threshold register and seven-stage pipeline
// depends on pdto_pkg, pdto_front, pdto_step, pdto_blend, pdto_scale

// One pixel pair goes in and one overlay pixel comes out per clock when the output is
// not stalled; the sustained rate is one transaction per cycle only while ovl_ready is
// high. The pipeline has one classify stage, four divider stages that each resolve two
// quotient bits of the blue alpha (difference*200/threshold), one blend stage and one
// reciprocal-multiply stage that divides by 1000 into the output register. Every stage
// has its own valid bit, so empty stages keep filling while a result waits at the
// output. diff_threshold is written through cfg_we/cfg_wdata and should only change
// while the pipeline is empty.
module pixel_diff_tolerance_overlay_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  input  logic            pair_valid,
  output logic            pair_ready,
  input  pdto_pkg::pair_t pair_data,
  output logic            ovl_valid,
  input  logic            ovl_ready,
  output pdto_pkg::ovl_t  ovl_data
);

  logic [7:0] diff_threshold;

  logic             w_valid [5];
  logic             w_ready [5];
  pdto_pkg::work_t  w_data  [5];
  logic             b_valid, b_ready;
  pdto_pkg::blend_t b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= 8'd0;
    end else if (cfg_we) begin
      diff_threshold <= cfg_wdata;
    end
  end

  pdto_front u_front (
    .clk      (clk),
    .rst      (rst),
    .thr      (diff_threshold),
    .up_valid (pair_valid),
    .up_ready (pair_ready),
    .up_data  (pair_data),
    .dn_valid (w_valid[0]),
    .dn_ready (w_ready[0]),
    .dn_data  (w_data[0])
  );

  for (genvar i = 0; i < 4; i++) begin : g_div
    pdto_step #(
      .STEP (3 - i)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (w_valid[i]),
      .up_ready (w_ready[i]),
      .up_data  (w_data[i]),
      .dn_valid (w_valid[i+1]),
      .dn_ready (w_ready[i+1]),
      .dn_data  (w_data[i+1])
    );
  end

  pdto_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .up_valid (w_valid[4]),
    .up_ready (w_ready[4]),
    .up_data  (w_data[4]),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  pdto_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (b_valid),
    .up_ready (b_ready),
    .up_data  (b_data),
    .dn_valid (ovl_valid),
    .dn_ready (ovl_ready),
    .dn_data  (ovl_data)
  );

endmodule

// File: hw/rtl/pdto_front.sv
// first pipeline stage: channel differences, maximum and case classification
// depends on pdto_pkg
module pdto_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      thr,
  input  logic            up_valid,
  output logic            up_ready,
  input  pdto_pkg::pair_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pdto_pkg::work_t dn_data
);

  logic [7:0] dr, dg, db, dmax;
  pdto_pkg::work_t data_next;

  always_comb begin
    dr = (up_data.ref_pixel.red > up_data.cmp_pixel.red) ?
         up_data.ref_pixel.red - up_data.cmp_pixel.red :
         up_data.cmp_pixel.red - up_data.ref_pixel.red;
    dg = (up_data.ref_pixel.green > up_data.cmp_pixel.green) ?
         up_data.ref_pixel.green - up_data.cmp_pixel.green :
         up_data.cmp_pixel.green - up_data.ref_pixel.green;
    db = (up_data.ref_pixel.blue > up_data.cmp_pixel.blue) ?
         up_data.ref_pixel.blue - up_data.cmp_pixel.blue :
         up_data.cmp_pixel.blue - up_data.ref_pixel.blue;
    dmax = dr;
    if (dg > dmax) dmax = dg;
    if (db > dmax) dmax = db;
  end

  always_comb begin
    data_next       = '0;
    data_next.cmp   = up_data.cmp_pixel;
    data_next.diff  = dmax;
    data_next.thr   = thr;
    // dividend for the blue alpha: floor(d*200/thr) is 200*t/1000 folded
    data_next.rem   = 16'(dmax) * 16'(pdto_pkg::BLUE_SCALE);
    if (up_data.ref_outside) begin
      data_next.kind = pdto_pkg::KIND_OUTSIDE;
    end else if (dmax == 8'd0) begin
      data_next.kind = pdto_pkg::KIND_GRAY;
    end else if (dmax > thr) begin
      data_next.kind = pdto_pkg::KIND_RED;
    end else begin
      data_next.kind = pdto_pkg::KIND_BLUE;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// File: hw/rtl/pdto_step.sv
// one divider stage: two quotient bits of d*200/thr, plus a slice of red alpha math
// depends on pdto_pkg; instanced with STEP from 3 down to 0
module pdto_step #(
  parameter int STEP = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  pdto_pkg::work_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pdto_pkg::work_t dn_data
);

  localparam int BIT_HI = 2 * STEP + 1;
  localparam int BIT_LO = 2 * STEP;

  logic [15:0] dvs_hi, dvs_lo, rem_mid, rem_out;
  logic        q_hi, q_lo;
  logic [9:0]  red_t_next;
  logic [8:0]  red_q_next;
  pdto_pkg::work_t data_next;

  // restoring division; the quotient fits in 8 bits for blue pairs, the only kind that uses it
  always_comb begin
    dvs_hi  = 16'(up_data.thr) << BIT_HI;
    dvs_lo  = 16'(up_data.thr) << BIT_LO;
    q_hi    = (up_data.rem >= dvs_hi);
    rem_mid = q_hi ? up_data.rem - dvs_hi : up_data.rem;
    q_lo    = (rem_mid >= dvs_lo);
    rem_out = q_lo ? rem_mid - dvs_lo : rem_mid;
  end

  if (STEP == 3) begin : g_red_t
    logic [30:0] t_prod;
    logic [10:0] t_raw;
    always_comb begin
      t_prod     = 31'(up_data.diff) * 31'(pdto_pkg::RED_T_MUL);
      t_raw      = t_prod[pdto_pkg::RED_T_SHIFT +: 11];
      red_t_next = (t_raw > 11'(pdto_pkg::T_MAX)) ? pdto_pkg::T_MAX : t_raw[9:0];
      red_q_next = up_data.red_q;
    end
  end else if (STEP == 2) begin : g_red_q
    logic [12:0] t7;
    logic [26:0] q_prod;
    // 350*t/1000 == (7t/4)/5
    always_comb begin
      t7         = 13'(up_data.red_t) * 13'd7;
      q_prod     = 27'(t7[12:2]) * 27'(pdto_pkg::DIV5_MUL);
      red_q_next = q_prod[pdto_pkg::DIV5_SHIFT +: 9];
      red_t_next = up_data.red_t;
    end
  end else begin : g_red_pass
    always_comb begin
      red_t_next = up_data.red_t;
      red_q_next = up_data.red_q;
    end
  end

  always_comb begin
    data_next              = up_data;
    data_next.rem          = rem_out;
    data_next.quo[BIT_HI]  = q_hi;
    data_next.quo[BIT_LO]  = q_lo;
    data_next.red_t        = red_t_next;
    data_next.red_q        = red_q_next;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// File: hw/rtl/pdto_blend.sv
// alpha selection and blend numerators (or gray luminance sum) per channel
// depends on pdto_pkg
module pdto_blend (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  pdto_pkg::work_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output pdto_pkg::blend_t dn_data
);

  logic [9:0]  al, inv;
  logic [7:0]  tgt_r, tgt_g, tgt_b;
  logic [17:0] gray;
  pdto_pkg::blend_t data_next;

  always_comb begin
    al    = pdto_pkg::ALPHA_OUTSIDE;
    tgt_r = pdto_pkg::RED_TGT_R;
    tgt_g = pdto_pkg::RED_TGT_G;
    tgt_b = pdto_pkg::RED_TGT_B;
    case (up_data.kind)
      pdto_pkg::KIND_OUTSIDE: al = pdto_pkg::ALPHA_OUTSIDE;
      pdto_pkg::KIND_RED: begin
        al = pdto_pkg::RED_BASE + 10'(up_data.red_q);
      end
      pdto_pkg::KIND_BLUE: begin
        al    = pdto_pkg::BLUE_BASE + 10'(up_data.quo);
        tgt_r = pdto_pkg::BLUE_TGT_R;
        tgt_g = pdto_pkg::BLUE_TGT_G;
        tgt_b = pdto_pkg::BLUE_TGT_B;
      end
      default: al = pdto_pkg::ALPHA_OUTSIDE;
    endcase
    inv = pdto_pkg::ALPHA_FULL - al;
  end

  always_comb begin
    gray = 18'(up_data.cmp.red)   * 18'(pdto_pkg::GRAY_W_R)
         + 18'(up_data.cmp.green) * 18'(pdto_pkg::GRAY_W_G)
         + 18'(up_data.cmp.blue)  * 18'(pdto_pkg::GRAY_W_B);
    data_next.alpha = up_data.cmp.alpha;
    if (up_data.kind == pdto_pkg::KIND_GRAY) begin
      data_next.num_red   = gray;
      data_next.num_green = gray;
      data_next.num_blue  = gray;
    end else begin
      data_next.num_red   = 18'(up_data.cmp.red) * 18'(inv) + 18'(tgt_r) * 18'(al);
      data_next.num_green = 18'(up_data.cmp.green) * 18'(inv) + 18'(tgt_g) * 18'(al);
      data_next.num_blue  = 18'(up_data.cmp.blue) * 18'(inv) + 18'(tgt_b) * 18'(al);
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// File: hw/rtl/pdto_scale.sv
// last stage: divide the numerators by 1000 through a reciprocal, output register
// depends on pdto_pkg
module pdto_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  pdto_pkg::blend_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output pdto_pkg::ovl_t   dn_data
);

  logic [35:0] p_r, p_g, p_b;
  pdto_pkg::ovl_t data_next;

  // a blend of 8-bit values never exceeds 255, so no clamp is needed
  always_comb begin
    p_r = 36'(up_data.num_red)   * 36'(pdto_pkg::DIV1000_MUL);
    p_g = 36'(up_data.num_green) * 36'(pdto_pkg::DIV1000_MUL);
    p_b = 36'(up_data.num_blue)  * 36'(pdto_pkg::DIV1000_MUL);
    data_next.out_red   = p_r[pdto_pkg::DIV1000_SHIFT +: 8];
    data_next.out_green = p_g[pdto_pkg::DIV1000_SHIFT +: 8];
    data_next.out_blue  = p_b[pdto_pkg::DIV1000_SHIFT +: 8];
    data_next.out_alpha = up_data.alpha;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

// File: hw/rtl/pdto_checker.sv
// port-level checks for the pixel difference overlay, bound to the top level
// depends on pdto_pkg and pixel_diff_tolerance_overlay_unit
module pdto_checker (
  input logic            clk,
  input logic            rst,
  input logic            cfg_we,
  input logic [7:0]      cfg_wdata,
  input logic            pair_valid,
  input logic            pair_ready,
  input pdto_pkg::pair_t pair_data,
  input logic            ovl_valid,
  input logic            ovl_ready,
  input pdto_pkg::ovl_t  ovl_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ovl_valid && !ovl_ready |=> ovl_valid && $stable(ovl_data))
    else $error("overlay output changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !ovl_valid)
    else $error("output valid right after reset");

  // with the sink ready every stage can move, so the input is never blocked
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    ovl_ready |-> pair_ready)
    else $error("input blocked although output is ready");

  // an unstalled transaction appears at the output with the alpha of the compared pixel
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(pair_valid && pair_ready, 7) &&
    $past(ovl_ready, 1) && $past(ovl_ready, 2) && $past(ovl_ready, 3) &&
    $past(ovl_ready, 4) && $past(ovl_ready, 5) && $past(ovl_ready, 6) &&
    !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) &&
    !$past(rst, 5) && !$past(rst, 6) && !$past(rst, 7)
    |-> ovl_valid && ovl_data.out_alpha == $past(pair_data.cmp_pixel.alpha, 7))
    else $error("overlay transaction missing or wrong alpha after pipeline latency");

endmodule

bind pixel_diff_tolerance_overlay_unit pdto_checker u_pdto_checker (.*);

// File: tb/sv/pixel_diff_tolerance_overlay_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for pixel_diff_tolerance_overlay_unit: directed and random pixel pairs
// over several diff_threshold settings, each overlay pixel checked against a local predictor
// depends on pdto_pkg and pixel_diff_tolerance_overlay_unit
module pixel_diff_tolerance_overlay_unit_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_PAIRS    = 160;

  // overlay alphas and alpha spans, in 1/1000
  localparam int unsigned ALPHA_ONE     = 1000;
  localparam int unsigned OUTSIDE_ALPHA = 600;
  localparam int unsigned RED_ALPHA0    = 250;
  localparam int unsigned RED_ALPHA_SPAN  = 350;
  localparam int unsigned BLUE_ALPHA0   = 100;
  localparam int unsigned BLUE_ALPHA_SPAN = 200;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic   pair_valid = 1'b0;
  logic   pair_ready;
  pdto_pkg::pair_t pair_data = '0;
  logic   ovl_valid;
  logic   ovl_ready = 1'b0;
  pdto_pkg::ovl_t  ovl_data;

  pdto_pkg::pair_t pending_pairs[$];
  pdto_pkg::ovl_t  expected_pixels[$];
  logic [7:0] threshold_setting = 8'd0;
  bit     calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned ready_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  pdto_pkg::ovl_t  want;

  pixel_diff_tolerance_overlay_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair_data  (pair_data),
    .ovl_valid  (ovl_valid),
    .ovl_ready  (ovl_ready),
    .ovl_data   (ovl_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned chan_gap(logic [7:0] x, logic [7:0] y);
    return (x > y) ? 32'(x - y) : 32'(y - x);
  endfunction

  function automatic logic [7:0] blend_chan(logic [7:0] orig, int unsigned dst,
                                            int unsigned alpha);
    int unsigned v;
    v = (32'(orig) * (ALPHA_ONE - alpha) + dst * alpha) / ALPHA_ONE;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // expected overlay pixel for one pair under the given threshold
  function automatic pdto_pkg::ovl_t overlay_of(pdto_pkg::pair_t p, logic [7:0] thr);
    pdto_pkg::ovl_t  o;
    pdto_pkg::kind_t kind;
    pdto_pkg::argb_t a;
    pdto_pkg::argb_t b;
    int unsigned d;
    int unsigned t;
    int unsigned al;
    int unsigned gray;
    int unsigned thr_i;
    a = p.ref_pixel;
    b = p.cmp_pixel;
    thr_i = 32'(thr);
    d = chan_gap(a.red, b.red);
    if (chan_gap(a.green, b.green) > d) d = chan_gap(a.green, b.green);
    if (chan_gap(a.blue, b.blue) > d) d = chan_gap(a.blue, b.blue);
    if (p.ref_outside) kind = pdto_pkg::KIND_OUTSIDE;
    else if (d == 0) kind = pdto_pkg::KIND_GRAY;
    else if (d > thr_i) kind = pdto_pkg::KIND_RED;
    else kind = pdto_pkg::KIND_BLUE;
    o.out_alpha = b.alpha;
    case (kind)
      pdto_pkg::KIND_GRAY: begin
        gray = (299 * 32'(b.red) + 587 * 32'(b.green) + 114 * 32'(b.blue)) / 1000;
        o.out_red = gray[7:0];
        o.out_green = gray[7:0];
        o.out_blue = gray[7:0];
      end
      pdto_pkg::KIND_BLUE: begin
        t = (d * 1000) / ((thr_i == 0) ? 1 : thr_i);
        if (t > 1000) t = 1000;
        al = BLUE_ALPHA0 + (BLUE_ALPHA_SPAN * t) / 1000;
        o.out_red = blend_chan(b.red, 60, al);
        o.out_green = blend_chan(b.green, 100, al);
        o.out_blue = blend_chan(b.blue, 255, al);
      end
      default: begin
        if (kind == pdto_pkg::KIND_OUTSIDE) begin
          al = OUTSIDE_ALPHA;
        end else begin
          t = (d * 1500) / 255;
          if (t > 1000) t = 1000;
          al = RED_ALPHA0 + (RED_ALPHA_SPAN * t) / 1000;
        end
        o.out_red = blend_chan(b.red, 255, al);
        o.out_green = blend_chan(b.green, 50, al);
        o.out_blue = blend_chan(b.blue, 50, al);
      end
    endcase
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] c, int unsigned span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // nudged pairs, often near the threshold, plus equal, outside and fully random pairs
  function automatic pdto_pkg::pair_t random_pair(logic [7:0] thr);
    pdto_pkg::pair_t p;
    int unsigned pick;
    int unsigned span;
    p.ref_pixel = $urandom();
    p.cmp_pixel = $urandom();
    p.ref_outside = 1'b0;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 1) ? 32'(thr) + 2 : $urandom_range(1, 255);
    if (pick < 20) begin
      p.ref_outside = 1'b1;
    end else if (pick < 35) begin
      p.ref_pixel = p.cmp_pixel;
      p.ref_pixel.alpha = 8'($urandom());
    end else if (pick < 82) begin
      p.ref_pixel.red = nudge(p.cmp_pixel.red, span);
      p.ref_pixel.green = nudge(p.cmp_pixel.green, span);
      p.ref_pixel.blue = nudge(p.cmp_pixel.blue, span);
    end
    return p;
  endfunction

  task automatic queue_pair(logic [31:0] a, logic [31:0] b, logic outside);
    pdto_pkg::pair_t p;
    p.ref_pixel = pdto_pkg::argb_t'(a);
    p.cmp_pixel = pdto_pkg::argb_t'(b);
    p.ref_outside = outside;
    pending_pairs.push_back(p);
  endtask

  // every queued pair sent and every overlay pixel back, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || pair_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold_setting = v;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, exp_val);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      send_gap <= 0;
    end else if (!pair_valid || pair_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pair_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        pair_data <= pending_pairs.pop_front();
        pair_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      ovl_ready <= 1'b0;
      ready_stall <= 0;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      ovl_ready <= 1'b0;
    end else begin
      ovl_ready <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  // predict on input transaction, check on output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && pair_ready)
        expected_pixels.push_back(overlay_of(pair_data, threshold_setting));
      if (ovl_valid && ovl_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("overlay pixel with none expected", ovl_data, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (ovl_data.out_red !== want.out_red)
            report_mismatch("out_red", 32'(ovl_data.out_red), 32'(want.out_red));
          if (ovl_data.out_green !== want.out_green)
            report_mismatch("out_green", 32'(ovl_data.out_green), 32'(want.out_green));
          if (ovl_data.out_blue !== want.out_blue)
            report_mismatch("out_blue", 32'(ovl_data.out_blue), 32'(want.out_blue));
          if (ovl_data.out_alpha !== want.out_alpha)
            report_mismatch("out_alpha", 32'(ovl_data.out_alpha), 32'(want.out_alpha));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pair_valid && pair_ready) || (ovl_valid && ovl_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] thr;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // threshold at its reset value of zero: gray, outside, any difference is red
    queue_pair(32'h00000000, 32'h00000000, 1'b0);
    queue_pair(32'h12FFFFFF, 32'hFFFFFFFF, 1'b0);
    queue_pair(32'h00804020, 32'h7F804020, 1'b0);
    queue_pair(32'h5A3C2D1E, 32'hFFFFFFFF, 1'b1);
    queue_pair(32'hFFFFFFFF, 32'h00000000, 1'b1);
    queue_pair(32'h80123456, 32'h80123456, 1'b1);
    queue_pair(32'h00000001, 32'h00000000, 1'b0);
    queue_pair(32'h00FFFFFF, 32'hFF000000, 1'b0);
    queue_pair(32'h0000FF00, 32'hA5000000, 1'b0);
    drain();

    // widest threshold: every nonzero difference of an inside pair is blue, the largest at full scale
    write_threshold(8'd255);
    queue_pair(32'h00000100, 32'h33000000, 1'b0);
    queue_pair(32'h00800000, 32'h44000000, 1'b0);
    queue_pair(32'h00FFFFFF, 32'hFF000000, 1'b0);
    queue_pair(32'h00000000, 32'hFFFFFFFF, 1'b0);
    queue_pair(32'hFF204060, 32'h01204060, 1'b0);
    queue_pair(32'h00000000, 32'h80FFFFFF, 1'b1);
    drain();

    // threshold 100: edges of blue and red, red alpha saturating at difference 170
    write_threshold(8'd100);
    queue_pair(32'h00640000, 32'h10000000, 1'b0);
    queue_pair(32'h00000065, 32'h20000000, 1'b0);
    queue_pair(32'h000000AA, 32'h30000000, 1'b0);
    queue_pair(32'h0000AB00, 32'h40000000, 1'b0);
    queue_pair(32'h00000032, 32'h500000FF, 1'b0);
    queue_pair(32'h00FF0000, 32'h60FF0063, 1'b0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: thr = 8'd1;
        1: thr = 8'd255;
        2: thr = 8'd0;
        3: thr = 8'd128;
        default: thr = 8'($urandom_range(0, 255));
      endcase
      write_threshold(thr);
      calm = (ph == 2 || ph == 5);
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        // hold the sender halfway until the pipeline has emptied
        if (n == PHASE_PAIRS / 2) drain();
        pending_pairs.push_back(random_pair(thr));
      end
      drain();
    end

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch("overlay pixels never returned", 32'(expected_pixels.size()), '0);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pdto_pkg.sv
hw/rtl/pdto_front.sv
hw/rtl/pdto_step.sv
hw/rtl/pdto_blend.sv
hw/rtl/pdto_scale.sv
hw/rtl/pixel_diff_tolerance_overlay_unit.sv
hw/rtl/pdto_checker.sv
tb/sv/pixel_diff_tolerance_overlay_unit_tb.sv
